/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds at a rising edge of clk_i outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/pngru_pkg.sv */
// Package with the filter type and register indexes of the PNG row unfilter.
package pngru_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_LEFT  = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_e;

  localparam logic [1:0] CFG_COLORS  = 2'd0;
  localparam logic [1:0] CFG_BPC     = 2'd1;
  localparam logic [1:0] CFG_COLUMNS = 2'd2;
  localparam logic [1:0] CFG_ROWS    = 2'd3;

  localparam logic [7:0] MAX_TAG = 8'd4;

endpackage

/* rtl/pngru_line_store.sv */
// Line store holding the previous reconstructed row, with a registered read port.
module pngru_line_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] store_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pngru_predict.sv */
// Byte reconstruction for the None, Left, Up, Average and Paeth filters.
module pngru_predict import pngru_pkg::*; (
  input  filter_e    filter_i,
  input  logic [7:0] data_i,
  input  logic [7:0] left_i,
  input  logic [7:0] up_i,
  input  logic [7:0] upleft_i,
  output logic [7:0] val_o
);

  logic [8:0]         avg_sum;
  logic [7:0]         dist_a;
  logic [7:0]         dist_b;
  logic signed [10:0] grad;
  logic [9:0]         dist_c;
  logic [7:0]         paeth;

  always_comb begin
    avg_sum = {1'b0, left_i} + {1'b0, up_i};
    dist_a  = (up_i >= upleft_i) ? (up_i - upleft_i) : (upleft_i - up_i);
    dist_b  = (left_i >= upleft_i) ? (left_i - upleft_i) : (upleft_i - left_i);
    grad    = $signed({3'b000, left_i}) + $signed({3'b000, up_i})
              - $signed({2'b00, upleft_i, 1'b0});
    dist_c  = (grad < 0) ? 10'(-grad) : 10'(grad);
    if (({2'b00, dist_a} <= dist_c) && (dist_a <= dist_b)) begin
      paeth = left_i;
    end else if ({2'b00, dist_b} <= dist_c) begin
      paeth = up_i;
    end else begin
      paeth = upleft_i;
    end
  end

  always_comb begin
    case (filter_i)
      FILT_LEFT:  val_o = data_i + left_i;
      FILT_UP:    val_o = data_i + up_i;
      FILT_AVG:   val_o = data_i + avg_sum[8:1];
      FILT_PAETH: val_o = data_i + paeth;
      default:    val_o = data_i;
    endcase
  end

endmodule

/* rtl/png_row_unfilter.sv */
// Top level of the PNG row unfilter: control, line store access and result register.
//
// The input channel carries the filtered byte stream one byte per transfer.
// The first byte of each row is its filter tag and gives no result; every
// data byte gives one result on the output channel with row and image end
// flags and a flag for a row whose tag is above four, which passes unchanged.
// image_start_i on a transfer makes that byte the tag of row zero.
// Configuration is written through the cfg channel, which is always ready.
// The input is stalled in the cycle of a configuration write and the cycle
// after it, while the row and pixel lengths are recomputed.
// An accepted byte goes through the stage register to the result register.
// Throughput is one byte per cycle, tags included, while the input is not stalled;
// the line store has one read port used at accept, one write port at stage exit.
// When the receiver stalls, the result register holds and the input stalls
// once the stage in front of it is also full; nothing is lost.
// Reset clears the control state and the configuration to one 8-bit color
// per pixel, one column and one row; the line store is not cleared, and the
// first row of each image reads zero for the row above.
module png_row_unfilter import pngru_pkg::*; #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        image_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        row_end_o,
  output logic        image_end_o,
  output logic        bad_tag_o
);

  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [2:0]  colors_q;
  logic [4:0]  bpc_q;
  logic [13:0] columns_q;
  logic [15:0] row_count_q;
  logic        settle_q;
  logic        cfg_wr;

  logic [7:0]     comp_bits;
  logic [21:0]    row_bits;
  logic [18:0]    row_raw;
  logic [5:0]     pix_raw;
  logic [31:0]    rb_w;
  logic [31:0]    pb_w;
  logic [RBW-1:0] rb_d, rb_q;
  logic [PW-1:0]  pb_idx_d, pb_idx_q;

  logic          awaiting_d, awaiting_q;
  filter_e       filter_d, filter_q;
  logic [AW-1:0] byte_pos_d, byte_pos_q;
  logic [15:0]   row_pos_d, row_pos_q;

  logic        in_accept;
  logic        awaiting_eff;
  logic [15:0] row_pos_eff;
  logic        ends_row;
  logic        ends_image;
  logic        adv1;

  logic          s1_valid_q;
  logic          s1_tag_q;
  logic [7:0]    s1_data_q;
  filter_e       s1_filter_q;
  logic          s1_upzero_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_row_end_q;
  logic          s1_image_end_q;

  logic [MAX_PIXEL_BYTES-1:0][7:0] left_hist_q;
  logic [MAX_PIXEL_BYTES-1:0][7:0] upleft_hist_q;

  logic [7:0] mem_rdata;
  logic [7:0] up;
  logic [7:0] left;
  logic [7:0] upleft;
  logic [7:0] val;
  logic       out_load;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_row_end_q;
  logic       out_image_end_q;
  logic       out_bad_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q    <= 3'd1;
      bpc_q       <= 5'd8;
      columns_q   <= 14'd1;
      row_count_q <= 16'd1;
      settle_q    <= 1'b0;
    end else begin
      settle_q <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index_i)
          CFG_COLORS:  colors_q    <= cfg_data_i[2:0];
          CFG_BPC:     bpc_q       <= cfg_data_i[4:0];
          CFG_COLUMNS: columns_q   <= cfg_data_i[13:0];
          CFG_ROWS:    row_count_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_comb begin
    comp_bits = {5'b00000, colors_q} * {3'b000, bpc_q};
    row_bits  = 22'(comp_bits) * 22'(columns_q);
    row_raw   = 19'((row_bits + 22'd7) >> 3);
    pix_raw   = 6'(({1'b0, comp_bits} + 9'd7) >> 3);
    if (row_raw == '0) begin
      rb_w = 32'd1;
    end else if (32'(row_raw) > 32'(MAX_ROW_BYTES)) begin
      rb_w = 32'(MAX_ROW_BYTES);
    end else begin
      rb_w = 32'(row_raw);
    end
    if (pix_raw == '0) begin
      pb_w = 32'd1;
    end else if (32'(pix_raw) > 32'(MAX_PIXEL_BYTES)) begin
      pb_w = 32'(MAX_PIXEL_BYTES);
    end else begin
      pb_w = 32'(pix_raw);
    end
    rb_d     = RBW'(rb_w);
    pb_idx_d = PW'(pb_w - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q     <= RBW'(1);
      pb_idx_q <= '0;
    end else begin
      rb_q     <= rb_d;
      pb_idx_q <= pb_idx_d;
    end
  end

  assign adv1       = s1_valid_q & (s1_tag_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = (s1_valid_q & ~adv1) | cfg_valid_i | settle_q;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    awaiting_eff = image_start_i | awaiting_q;
    row_pos_eff  = image_start_i ? 16'd0 : row_pos_q;
    ends_row     = (32'(byte_pos_q) + 32'd1) >= 32'(rb_q);
    ends_image   = ({1'b0, row_pos_eff} + 17'd1) >= {1'b0, row_count_q};
    awaiting_d   = awaiting_q;
    filter_d     = filter_q;
    byte_pos_d   = byte_pos_q;
    row_pos_d    = row_pos_q;
    if (in_accept) begin
      if (awaiting_eff) begin
        awaiting_d = 1'b0;
        filter_d   = (in_byte_i > MAX_TAG) ? FILT_BAD : filter_e'(in_byte_i[2:0]);
        byte_pos_d = '0;
        row_pos_d  = row_pos_eff;
      end else if (ends_row) begin
        awaiting_d = 1'b1;
        byte_pos_d = '0;
        row_pos_d  = ends_image ? 16'd0 : row_pos_eff + 16'd1;
      end else begin
        byte_pos_d = byte_pos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      filter_q   <= FILT_NONE;
      byte_pos_q <= '0;
      row_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      awaiting_q <= awaiting_d;
      filter_q   <= filter_d;
      byte_pos_q <= byte_pos_d;
      row_pos_q  <= row_pos_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tag_q       <= awaiting_eff;
      s1_data_q      <= in_byte_i;
      s1_filter_q    <= filter_q;
      s1_upzero_q    <= (row_pos_eff == 16'd0);
      s1_idx_q       <= byte_pos_q;
      s1_row_end_q   <= ends_row;
      s1_image_end_q <= ends_row & ends_image;
    end
  end

  pngru_line_store #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (adv1 & ~s1_tag_q),
    .waddr_i (s1_idx_q),
    .wdata_i (val),
    .re_i    (in_accept & ~awaiting_eff),
    .raddr_i (byte_pos_q),
    .rdata_o (mem_rdata)
  );

  assign up     = s1_upzero_q ? 8'd0 : mem_rdata;
  assign left   = left_hist_q[pb_idx_q];
  assign upleft = upleft_hist_q[pb_idx_q];

  pngru_predict u_predict (
    .filter_i (s1_filter_q),
    .data_i   (s1_data_q),
    .left_i   (left),
    .up_i     (up),
    .upleft_i (upleft),
    .val_o    (val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hist_q   <= '0;
      upleft_hist_q <= '0;
    end else if (adv1) begin
      if (s1_tag_q) begin
        left_hist_q   <= '0;
        upleft_hist_q <= '0;
      end else begin
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          left_hist_q[i]   <= left_hist_q[i-1];
          upleft_hist_q[i] <= upleft_hist_q[i-1];
        end
        left_hist_q[0]   <= val;
        upleft_hist_q[0] <= up;
      end
    end
  end

  assign out_load = adv1 & ~s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q      <= val;
      out_row_end_q   <= s1_row_end_q;
      out_image_end_q <= s1_image_end_q;
      out_bad_q       <= (s1_filter_q == FILT_BAD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign row_end_o   = out_row_end_q;
  assign image_end_o = out_image_end_q;
  assign bad_tag_o   = out_bad_q;

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_no_same_entry, (adv1 && !s1_tag_q && in_accept && !awaiting_eff && (s1_idx_q == byte_pos_q)), "line store read and write hit the same entry")
  `ASSERT_CLK(a_accept_fills_stage, (in_accept |=> s1_valid_q), "accepted byte missing from stage")
  `ASSERT_CLK(a_data_gives_result, (out_load |=> out_valid_q), "data byte gave no result")
  `ASSERT_CLK(a_image_end_on_row_end, ((out_valid_q && out_image_end_q) |-> out_row_end_q), "image end without row end")

endmodule
